/* rtl/base64_stream_decoder_top_macros.svh */
// ----------------------------------------------------------------------------
// base64 stream decoder assertion macros
// shared concurrent assertion forms for the decoder checker
// ----------------------------------------------------------------------------
`ifndef BASE64_STREAM_DECODER_TOP_MACROS_SVH
`define BASE64_STREAM_DECODER_TOP_MACROS_SVH

// checked on every rising clock edge outside reset
`define B64SD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked on every rising clock edge, reset included
`define B64SD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

/* rtl/b64sd_pkg.sv */
// ----------------------------------------------------------------------------
// b64sd_pkg
// types, constants and the character map of the base64 stream decoder
// ----------------------------------------------------------------------------
package b64sd_pkg;

  localparam int unsigned SymbolW    = 8;
  localparam int unsigned SextetW    = 6;
  localparam int unsigned PartialW   = 18;
  localparam int unsigned GroupW     = 24;
  localparam int unsigned FIFO_DEPTH = 4;

  localparam logic [7:0] CharUpperA = 8'd65;
  localparam logic [7:0] CharUpperZ = 8'd90;
  localparam logic [7:0] CharLowerA = 8'd97;
  localparam logic [7:0] CharLowerZ = 8'd122;
  localparam logic [7:0] CharDigit0 = 8'd48;
  localparam logic [7:0] CharDigit9 = 8'd57;
  localparam logic [7:0] CharPlus   = 8'd43;
  localparam logic [7:0] CharSlash  = 8'd47;

  localparam logic [7:0] LowerOffset = 8'd71;
  localparam logic [7:0] DigitOffset = 8'd4;
  localparam logic [5:0] PlusValue   = 6'd62;
  localparam logic [5:0] SlashValue  = 6'd63;

  localparam logic [1:0] LastPosition = 2'd3;

  typedef struct packed {
    logic [2:0]        keep;
    logic [GroupW-1:0] bits;
  } grp_t;

  function automatic logic [SextetW-1:0] sextet_of(input logic [SymbolW-1:0] c);
    logic [SymbolW-1:0] v;
    v = '0;
    if (c inside {[CharUpperA:CharUpperZ]}) begin
      v = c - CharUpperA;
    end else if (c inside {[CharLowerA:CharLowerZ]}) begin
      v = c - LowerOffset;
    end else if (c inside {[CharDigit0:CharDigit9]}) begin
      v = c + DigitOffset;
    end else if (c == CharPlus) begin
      v = {2'b00, PlusValue};
    end else if (c == CharSlash) begin
      v = {2'b00, SlashValue};
    end
    return v[SextetW-1:0];
  endfunction

endpackage

/* rtl/b64sd_front.sv */
// ----------------------------------------------------------------------------
// b64sd_front
// maps characters to sextets and gathers four into a group for the queue
// ----------------------------------------------------------------------------
module b64sd_front import b64sd_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid_i,
  output logic               s_axis_tready_o,
  input  logic [SymbolW-1:0] s_axis_tdata_i,
  input  logic               s_axis_tlast_i,
  output logic               push_o,
  output grp_t               push_data_o,
  input  logic               full_i
);

  logic [PartialW-1:0] bits_q, bits_d;
  logic [1:0]          pos_q, pos_d;
  logic                accept;
  logic [SextetW-1:0]  sextet;
  logic [GroupW-1:0]   word;

  assign s_axis_tready_o = !full_i;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign sextet          = sextet_of(s_axis_tdata_i);
  assign word            = {bits_q, sextet};

  assign push_data_o.bits = word;
  assign push_data_o.keep = {word[23:16] != 8'd0, word[15:8] != 8'd0, word[7:0] != 8'd0};
  assign push_o           = accept && (pos_q == LastPosition) && (|push_data_o.keep);

  always_comb begin
    bits_d = bits_q;
    pos_d  = pos_q;
    if (accept) begin
      if (pos_q == LastPosition || s_axis_tlast_i) begin
        bits_d = '0;
        pos_d  = '0;
      end else begin
        bits_d = {bits_q[PartialW-SextetW-1:0], sextet};
        pos_d  = pos_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bits_q <= '0;
      pos_q  <= '0;
    end else begin
      bits_q <= bits_d;
      pos_q  <= pos_d;
    end
  end

endmodule

/* rtl/b64sd_fifo.sv */
// ----------------------------------------------------------------------------
// b64sd_fifo
// short group queue between the character front and the byte back
// ----------------------------------------------------------------------------
module b64sd_fifo import b64sd_pkg::*; #(
  parameter int unsigned Depth = FIFO_DEPTH
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  grp_t push_data_i,
  output logic full_o,
  input  logic pop_i,
  output grp_t pop_data_o,
  output logic empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  grp_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign full_o     = cnt_q == CntFull;
  assign empty_o    = cnt_q == '0;
  assign pop_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

/* rtl/b64sd_back.sv */
// ----------------------------------------------------------------------------
// b64sd_back
// unpacks queued groups into non-zero bytes behind an output register
// ----------------------------------------------------------------------------
module b64sd_back import b64sd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  output logic       pop_o,
  input  grp_t       pop_data_i,
  input  logic       empty_i,
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o,
  output logic       m_axis_tlast_o
);

  logic [2:0]        keep_q, keep_d, rem, keep_after;
  logic [GroupW-1:0] bits_q, bits_d;
  logic              valid_q, valid_d, last_q, last_d;
  logic [7:0]        data_q, data_d, byte_sel;
  logic              adv, emit;

  assign adv  = !valid_q || m_axis_tready_i;
  assign emit = adv && (|keep_q);

  always_comb begin
    if (keep_q[2]) begin
      byte_sel = bits_q[23:16];
      rem      = {1'b0, keep_q[1:0]};
    end else if (keep_q[1]) begin
      byte_sel = bits_q[15:8];
      rem      = {2'b00, keep_q[0]};
    end else begin
      byte_sel = bits_q[7:0];
      rem      = '0;
    end
  end

  assign keep_after = emit ? rem : keep_q;
  assign pop_o      = !empty_i && (keep_after == '0);

  always_comb begin
    keep_d  = pop_o ? pop_data_i.keep : keep_after;
    bits_d  = pop_o ? pop_data_i.bits : bits_q;
    valid_d = valid_q;
    data_d  = data_q;
    last_d  = last_q;
    if (adv) begin
      valid_d = |keep_q;
      data_d  = byte_sel;
      last_d  = rem == '0;
    end
  end

  always_ff @(posedge clk_i) begin
    bits_q <= bits_d;
    data_q <= data_d;
    last_q <= last_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      keep_q  <= '0;
      valid_q <= 1'b0;
    end else begin
      keep_q  <= keep_d;
      valid_q <= valid_d;
    end
  end

  assign m_axis_tvalid_o = valid_q;
  assign m_axis_tdata_o  = data_q;
  assign m_axis_tlast_o  = last_q;

endmodule

/* rtl/base64_stream_decoder_top.sv */
// ----------------------------------------------------------------------------
// base64_stream_decoder_top
// base64 character stream in, decoded non-zero bytes out
// ----------------------------------------------------------------------------
// One base64 character is taken per clock cycle. Every fourth character
// closes a group whose non-zero bytes leave most significant first, one per
// cycle through a registered output, tlast on the group's final byte; a
// group decodes to at most three bytes, so output keeps pace with input.
// A character with tlast that does not close a group drops the partial
// group. Input ready falls only while the group queue (QueueDepth entries)
// is full because the output side is stalled; a closing character's group
// passes the queue, the back end's group register and the output register.
module base64_stream_decoder_top import b64sd_pkg::*; #(
  parameter int unsigned QueueDepth = FIFO_DEPTH
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,  // symbol
  input  logic       s_axis_tlast_i,
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o,  // data_byte
  output logic       m_axis_tlast_o
);

  logic push, full, pop, empty;
  grp_t push_data, pop_data;

  b64sd_front u_front (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid_i,
    .s_axis_tready_o,
    .s_axis_tdata_i,
    .s_axis_tlast_i,
    .push_o      (push),
    .push_data_o (push_data),
    .full_i      (full)
  );

  b64sd_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i,
    .rst_ni,
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .empty_o     (empty)
  );

  b64sd_back u_back (
    .clk_i,
    .rst_ni,
    .pop_o      (pop),
    .pop_data_i (pop_data),
    .empty_i    (empty),
    .m_axis_tvalid_o,
    .m_axis_tready_i,
    .m_axis_tdata_o,
    .m_axis_tlast_o
  );

endmodule

/* rtl/b64sd_checker.sv */
// ----------------------------------------------------------------------------
// b64sd_checker
// port-level checks of the base64 stream decoder, bound to the top level
// ----------------------------------------------------------------------------
`include "base64_stream_decoder_top_macros.svh"

module b64sd_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       s_axis_tvalid_i,
  input logic       s_axis_tready_o,
  input logic [7:0] s_axis_tdata_i,
  input logic       s_axis_tlast_i,
  input logic       m_axis_tvalid_o,
  input logic       m_axis_tready_i,
  input logic [7:0] m_axis_tdata_o,
  input logic       m_axis_tlast_o
);

  logic       stall;
  logic [8:0] out_word;
  assign stall    = m_axis_tvalid_o && !m_axis_tready_i;
  assign out_word = {m_axis_tlast_o, m_axis_tdata_o};

  `B64SD_ASSERT(a_nonzero_word, m_axis_tvalid_o |-> m_axis_tdata_o != 8'd0, "zero word emitted")
  `B64SD_ASSERT_ALWAYS(a_reset_state, !rst_ni |=> !m_axis_tvalid_o && s_axis_tready_o, "bad reset")
  `B64SD_ASSERT(a_stall_valid, stall |=> m_axis_tvalid_o, "valid dropped under stall")
  `B64SD_ASSERT(a_stall_data, stall |=> $stable(out_word), "word changed under stall")

endmodule

bind base64_stream_decoder_top b64sd_checker u_b64sd_checker (.*);
